// ===== src/lgrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lgrs_pkg;

  localparam int GridSizeDef = 8;

  localparam int ModeW      = 2;
  localparam int LoadRowW   = 3;
  localparam int LoadBitsW  = 8;
  localparam int DriveW     = 8;
  localparam int GenLimitW  = 7;
  localparam int StillLimW  = 3;
  localparam int GenCountW  = 8;
  localparam int StillCntW  = 4;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 7;
  localparam int InDataW    = 16;
  localparam int OutDataW   = 24;

  localparam logic [GenLimitW-1:0] GenLimitRst   = 7'd70;
  localparam logic [StillLimW-1:0] StillLimitRst = 3'd3;
  localparam logic [DriveW-1:0]    ColsRst       = 8'h00;
  localparam logic [DriveW-1:0]    RowsRst       = 8'hFF;
  localparam logic [DriveW-1:0]    RowBit0       = 8'h01;

  typedef enum logic [ModeW-1:0] {
    MODE_TICK = 2'd0,
    MODE_GEN  = 2'd1,
    MODE_LOAD = 2'd2,
    MODE_NONE = 2'd3
  } lgrs_mode_e;

  localparam logic [CfgIdxW-1:0] RegGenLimit   = 1'b0;
  localparam logic [CfgIdxW-1:0] RegStillLimit = 1'b1;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } lgrs_state_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } lgrs_cmd_t;

  typedef struct packed {
    logic out_full;
  } lgrs_status_t;

endpackage
`default_nettype wire

// ===== src/lgrs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lgrs_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  out_ready_i,
  input  wire lgrs_pkg::lgrs_status_t status_i,
  output lgrs_pkg::lgrs_cmd_t        cmd_o
);
  import lgrs_pkg::*;

  lgrs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // result slot must be free (or draining this cycle) before the update
        if (!status_i.out_full || out_ready_i) begin
          cmd_o.execute = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/lgrs_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lgrs_dp #(
  parameter int GRID_SIZE = lgrs_pkg::GridSizeDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire lgrs_pkg::lgrs_cmd_t             cmd_i,
  output lgrs_pkg::lgrs_status_t               status_o,
  input  wire logic                            out_ready_i,
  input  wire logic [lgrs_pkg::ModeW-1:0]      mode_i,
  input  wire logic [lgrs_pkg::LoadRowW-1:0]   load_row_i,
  input  wire logic [lgrs_pkg::LoadBitsW-1:0]  load_bits_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [lgrs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [lgrs_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output logic                                 out_valid_o,
  output logic [lgrs_pkg::DriveW-1:0]          column_drive_o,
  output logic [lgrs_pkg::DriveW-1:0]          row_drive_o,
  output logic                                 cells_changed_o,
  output logic                                 reseed_request_o
);
  import lgrs_pkg::*;

  localparam int RowW = $clog2(GRID_SIZE);
  localparam int ExtW = (GRID_SIZE > DriveW) ? GRID_SIZE : DriveW;

  function automatic logic [3:0] count8(input logic [7:0] nb);
    logic [3:0] s;
    s = '0;
    for (int k = 0; k < 8; k++) begin
      s = s + {3'b000, nb[k]};
    end
    return s;
  endfunction

  // captured item
  lgrs_mode_e               mode_q;
  logic [LoadRowW-1:0]      lrow_q;
  logic [LoadBitsW-1:0]     lbits_q;

  logic [GenLimitW-1:0]     gen_limit_q;
  logic [StillLimW-1:0]     still_limit_q;

  logic [GRID_SIZE-1:0]     grid_q [GRID_SIZE];
  logic [GRID_SIZE-1:0]     grid_next [GRID_SIZE];
  logic [GRID_SIZE+1:0]     pad [GRID_SIZE+2];
  logic [RowW-1:0]          scan_q, scan_d;
  logic [GenCountW-1:0]     gen_cnt_q, gen_cnt_d;
  logic [StillCntW-1:0]     still_cnt_q, still_cnt_d;
  logic [DriveW-1:0]        cols_q, rows_q;
  logic                     changed_q, reseed_q, out_vld_q;
  logic                     any_change, reseed_d;
  logic [ExtW-1:0]          scan_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= lgrs_mode_e'(mode_i);
      lrow_q  <= load_row_i;
      lbits_q <= load_bits_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_limit_q   <= GenLimitRst;
      still_limit_q <= StillLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegGenLimit:   gen_limit_q   <= cfg_wdata_i[GenLimitW-1:0];
        RegStillLimit: still_limit_q <= cfg_wdata_i[StillLimW-1:0];
        default: ;
      endcase
    end
  end

  // border of dead cells around the grid
  always_comb begin
    for (int r = 0; r < GRID_SIZE + 2; r++) begin
      pad[r] = '0;
    end
    for (int r = 0; r < GRID_SIZE; r++) begin
      pad[r+1] = {1'b0, grid_q[r], 1'b0};
    end
  end

  always_comb begin
    logic [3:0] n;
    logic       alive, live;
    any_change = 1'b0;
    for (int r = 0; r < GRID_SIZE; r++) begin
      grid_next[r] = '0;
      for (int c = 0; c < GRID_SIZE; c++) begin
        n = count8({pad[r][c], pad[r][c+1], pad[r][c+2],
                    pad[r+1][c], pad[r+1][c+2],
                    pad[r+2][c], pad[r+2][c+1], pad[r+2][c+2]});
        alive = grid_q[r][c];
        live  = (n == 4'd3) || (alive && (n == 4'd2));
        grid_next[r][c] = live;
        if (live != alive) begin
          any_change = 1'b1;
        end
      end
    end
  end

  always_comb begin
    gen_cnt_d   = gen_cnt_q + 1'b1;
    still_cnt_d = still_cnt_q;
    reseed_d    = 1'b0;
    if (gen_cnt_d > {1'b0, gen_limit_q}) begin
      gen_cnt_d = '0;
      reseed_d  = 1'b1;
    end
    if (!any_change) begin
      still_cnt_d = still_cnt_q + 1'b1;
      if (still_cnt_d > {1'b0, still_limit_q}) begin
        still_cnt_d = '0;
        gen_cnt_d   = '0;
        reseed_d    = 1'b1;
      end
    end
  end

  assign scan_ext = ExtW'(grid_q[scan_q]);
  assign scan_d   = (scan_q == RowW'(GRID_SIZE - 1)) ? '0 : scan_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < GRID_SIZE; r++) begin
        grid_q[r] <= '0;
      end
      scan_q      <= '0;
      gen_cnt_q   <= '0;
      still_cnt_q <= '0;
      cols_q      <= ColsRst;
      rows_q      <= RowsRst;
      changed_q   <= 1'b0;
      reseed_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cmd_i.execute) begin
        out_vld_q <= 1'b1;
        reseed_q  <= 1'b0;
        case (mode_q)
          MODE_TICK: begin
            cols_q <= scan_ext[DriveW-1:0];
            rows_q <= (32'(scan_q) < DriveW) ? ~(RowBit0 << scan_q) : RowsRst;
            scan_q <= scan_d;
          end
          MODE_GEN: begin
            grid_q      <= grid_next;
            gen_cnt_q   <= gen_cnt_d;
            still_cnt_q <= still_cnt_d;
            changed_q   <= any_change;
            reseed_q    <= reseed_d;
          end
          MODE_LOAD: begin
            if (32'(lrow_q) < GRID_SIZE) begin
              grid_q[RowW'(lrow_q)] <= GRID_SIZE'(lbits_q);
            end
          end
          default: ;
        endcase
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign status_o.out_full = out_vld_q;
  assign out_valid_o       = out_vld_q;
  assign column_drive_o    = cols_q;
  assign row_drive_o       = rows_q;
  assign cells_changed_o   = changed_q;
  assign reseed_request_o  = reseed_q;

endmodule
`default_nettype wire

// ===== src/life_grid_with_row_scan_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: mode; tdata: load_row, load_bits
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: column_drive, row_drive,
//                                              cells_changed, reseed_request
// cfg       in   cfg_we_i (no handshake)       cfg_idx_i, cfg_wdata_i
//
// Each item is registered in the idle state, then the grid/scan/load update in
// the execute state writes the result register. A whole generation is evaluated
// within that single update. The next item is taken while the result waits;
// a stalled result holds the second item in the execute state.
// Reset (async, active low) kills all cells, clears counters and scan, rows 0xFF.
module life_grid_with_row_scan_top #(
  parameter int GRID_SIZE = lgrs_pkg::GridSizeDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [lgrs_pkg::InDataW-1:0]   s_axis_tdata,  // load_row, load_bits
  input  wire logic [lgrs_pkg::ModeW-1:0]     s_axis_tuser,  // mode
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // column_drive, row_drive, cells_changed, reseed_request
  output logic [lgrs_pkg::OutDataW-1:0]       m_axis_tdata,
  input  wire logic                           cfg_we_i,
  input  wire logic [lgrs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [lgrs_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import lgrs_pkg::*;

  lgrs_cmd_t           cmd;
  lgrs_status_t        status;
  logic [DriveW-1:0]   column_drive, row_drive;
  logic                cells_changed, reseed_request;

  lgrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lgrs_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (m_axis_tready),
    .mode_i           (s_axis_tuser),
    .load_row_i       (s_axis_tdata[LoadRowW-1:0]),
    .load_bits_i      (s_axis_tdata[LoadRowW+LoadBitsW-1:LoadRowW]),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_valid_o      (m_axis_tvalid),
    .column_drive_o   (column_drive),
    .row_drive_o      (row_drive),
    .cells_changed_o  (cells_changed),
    .reseed_request_o (reseed_request)
  );

  assign m_axis_tdata = {6'b000000, reseed_request, cells_changed, row_drive, column_drive};

endmodule
`default_nettype wire
